// ----- sv/cbf_pkg.sv -----
// shared codes, sizes and state type of the command byte fifo
`timescale 1ns / 1ps

package cbf_pkg;

  // operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_SKIP = 2'd3;

  // access width codes (both unnamed codes are taken as four bytes)
  localparam logic [1:0] AW_ONE  = 2'd0;
  localparam logic [1:0] AW_TWO  = 2'd1;

  // one push moves a fixed block
  localparam int BLOCK_BYTES = 32;
  localparam int BLK_CNT_W   = $clog2(BLOCK_BYTES);

  // fixed field widths
  localparam int OFFSET_W = 12;
  localparam int SKIP_W   = 13;
  localparam int FILL_W   = 13;
  localparam int DATA_W   = 32;
  localparam int WORD_W   = 64;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WRITE = 3'b010,
    ST_READ  = 3'b100
  } state_t;

  // byte count of a read or peek
  function automatic logic [2:0] width_bytes(input logic [1:0] code);
    logic [2:0] n;
    case (code)
      AW_ONE:  n = 3'd1;
      AW_TWO:  n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

// ----- sv/command_byte_fifo_be_reads_core.sv -----
// command byte fifo: ring of bytes, 32-byte block push, big-endian multi-width reads
`timescale 1ns / 1ps
// push is busy while its 32-byte block is written, one byte per cycle; its result strobes
//   once the last byte is written. read and peek of n bytes stay busy while the bytes are read,
//   one byte per cycle through the single registered read port; the result follows the last byte.
// skip, overflow and underrun results strobe in the cycle after acceptance with busy low,
//   so such items may follow every cycle. the receiver cannot stall the result strobe.
// reset (rst_n low, synchronous) empties the fifo; the byte memory is not cleared.
module command_byte_fifo_be_reads_core #(
  parameter int STORE_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command side
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [1:0]                  in_access_width,
  input  logic [cbf_pkg::OFFSET_W-1:0] in_peek_offset,
  input  logic [cbf_pkg::SKIP_W-1:0]  in_skip_count,
  input  logic [cbf_pkg::WORD_W-1:0]  in_block_word_0,
  input  logic [cbf_pkg::WORD_W-1:0]  in_block_word_1,
  input  logic [cbf_pkg::WORD_W-1:0]  in_block_word_2,
  input  logic [cbf_pkg::WORD_W-1:0]  in_block_word_3,
  // result side
  output logic                        out_valid,
  output logic [cbf_pkg::DATA_W-1:0]  out_read_data,
  output logic [cbf_pkg::FILL_W-1:0]  out_fill_level,
  output logic                        out_underrun,
  output logic                        out_overflow
);

  // ring index, fill count and a wide compare width that holds every operand sum
  localparam int AW  = $clog2(STORE_BYTES);
  localparam int CW  = $clog2(STORE_BYTES + 1);
  localparam int WW  = ((CW > cbf_pkg::SKIP_W) ? CW : cbf_pkg::SKIP_W) + 1;
  localparam int BLK_W = 4 * cbf_pkg::WORD_W;

  // add on the ring; callers keep pos + amt below twice the store size
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] pos,
                                             input logic [WW-1:0] amt);
    logic [WW-1:0] s;
    s = WW'(pos) + amt;
    if (s >= WW'(STORE_BYTES)) begin
      s = s - WW'(STORE_BYTES);
    end
    return s[AW-1:0];
  endfunction

  // control state
  cbf_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]  rp_r, rp_nxt;        // oldest held byte
  logic [AW-1:0]  wp_r, wp_nxt;        // next byte to write
  logic [CW-1:0]  held_r, held_nxt;    // bytes held
  logic           out_valid_r, out_valid_nxt;

  // working registers of one item
  logic [BLK_W-1:0]                   block_r, block_nxt;   // push bytes, shifted out low first
  logic [cbf_pkg::BLK_CNT_W-1:0]      cnt_r, cnt_nxt;       // push byte counter
  logic [AW-1:0]                      addr_r, addr_nxt;     // next read address
  logic [2:0]                         n_r, n_nxt;           // bytes to gather
  logic [2:0]                         iss_r, iss_nxt;       // reads issued
  logic [2:0]                         got_r, got_nxt;       // bytes collected
  logic                               pend_r, pend_nxt;     // read data arrives this cycle
  logic                               consume_r, consume_nxt;
  logic [cbf_pkg::DATA_W-1:0]         acc_r, acc_nxt;       // big-endian gather

  // result registers
  logic [cbf_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic [cbf_pkg::FILL_W-1:0] out_fill_r, out_fill_nxt;
  logic                       out_under_r, out_under_nxt;
  logic                       out_over_r, out_over_nxt;

  // byte memory, one write and one registered read port
  logic [7:0]    byte_store_r [STORE_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_q_r;

  logic          accept;
  logic [2:0]    in_n;
  logic [WW-1:0] held_w;
  logic [WW-1:0] held_after;

  assign busy   = (state_r != cbf_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign in_n   = cbf_pkg::width_bytes(in_access_width);
  assign held_w = WW'(held_r);

  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    held_nxt      = held_r;
    block_nxt     = block_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    n_nxt         = n_r;
    iss_nxt       = iss_r;
    got_nxt       = got_r;
    pend_nxt      = 1'b0;
    consume_nxt   = consume_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    out_under_nxt = 1'b0;
    out_over_nxt  = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wp_r;
    mem_wdata     = block_r[7:0];
    mem_raddr     = addr_r;

    case (state_r)
      cbf_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            cbf_pkg::OP_PUSH: begin
              if (held_w > WW'(STORE_BYTES - cbf_pkg::BLOCK_BYTES)) begin
                // no room for a whole block: drop it
                out_valid_nxt = 1'b1;
                out_over_nxt  = 1'b1;
              end else begin
                block_nxt = {in_block_word_3, in_block_word_2,
                             in_block_word_1, in_block_word_0};
                cnt_nxt   = '0;
                state_nxt = cbf_pkg::ST_WRITE;
              end
            end
            cbf_pkg::OP_READ: begin
              if (WW'(in_n) > held_w) begin
                out_valid_nxt = 1'b1;
                out_under_nxt = 1'b1;
              end else begin
                addr_nxt    = rp_r;
                n_nxt       = in_n;
                iss_nxt     = '0;
                got_nxt     = '0;
                acc_nxt     = '0;
                consume_nxt = 1'b1;
                state_nxt   = cbf_pkg::ST_READ;
              end
            end
            cbf_pkg::OP_PEEK: begin
              if (WW'(in_peek_offset) + WW'(in_n) > held_w) begin
                out_valid_nxt = 1'b1;
                out_under_nxt = 1'b1;
              end else begin
                addr_nxt    = ring_add(rp_r, WW'(in_peek_offset));
                n_nxt       = in_n;
                iss_nxt     = '0;
                got_nxt     = '0;
                acc_nxt     = '0;
                consume_nxt = 1'b0;
                state_nxt   = cbf_pkg::ST_READ;
              end
            end
            default: begin
              // skip: pure pointer move, done at once
              out_valid_nxt = 1'b1;
              if (WW'(in_skip_count) > held_w) begin
                out_under_nxt = 1'b1;
              end else begin
                rp_nxt   = ring_add(rp_r, WW'(in_skip_count));
                held_nxt = held_r - CW'(in_skip_count);
              end
            end
          endcase
        end
      end
      cbf_pkg::ST_WRITE: begin
        // one block byte per cycle, lowest byte first
        mem_we    = 1'b1;
        block_nxt = block_r >> 8;
        wp_nxt    = ring_add(wp_r, WW'(1));
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == cbf_pkg::BLK_CNT_W'(cbf_pkg::BLOCK_BYTES - 1)) begin
          held_nxt      = held_r + CW'(cbf_pkg::BLOCK_BYTES);
          out_valid_nxt = 1'b1;
          state_nxt     = cbf_pkg::ST_IDLE;
        end
      end
      cbf_pkg::ST_READ: begin
        // issue one read per cycle, collect each byte in the cycle after its issue
        if (iss_r != n_r) begin
          addr_nxt = ring_add(addr_r, WW'(1));
          iss_nxt  = iss_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          acc_nxt = {acc_r[cbf_pkg::DATA_W-9:0], mem_q_r};
          got_nxt = got_r + 1'b1;
          if (got_r + 3'd1 == n_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = acc_nxt;
            state_nxt     = cbf_pkg::ST_IDLE;
            if (consume_r) begin
              // all n addresses issued, so addr_r already sits past the bytes read
              rp_nxt   = addr_r;
              held_nxt = held_r - CW'(n_r);
            end
          end
        end
      end
      default: begin
        state_nxt = cbf_pkg::ST_IDLE;
      end
    endcase

    held_after   = WW'(held_nxt);
    out_fill_nxt = held_after[cbf_pkg::FILL_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbf_pkg::ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    block_r     <= block_nxt;
    cnt_r       <= cnt_nxt;
    addr_r      <= addr_nxt;
    n_r         <= n_nxt;
    iss_r       <= iss_nxt;
    got_r       <= got_nxt;
    consume_r   <= consume_nxt;
    acc_r       <= acc_nxt;
    out_data_r  <= out_data_nxt;
    out_fill_r  <= out_fill_nxt;
    out_under_r <= out_under_nxt;
    out_over_r  <= out_over_nxt;
  end

  // byte memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store_r[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= byte_store_r[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;
  assign out_fill_level = out_fill_r;
  assign out_underrun   = out_under_r;
  assign out_overflow   = out_over_r;

`ifndef ASSERT_OFF
  // fill count never passes the store size
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(STORE_BYTES))
    else $error("fill count beyond store size");

  // between items the ring pointers and fill count agree
  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (ring_add(rp_r, WW'(held_r)) == wp_r))
    else $error("read pointer plus fill count differs from write pointer");

  // a result always leaves the block idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // at most one error flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_underrun && out_overflow))
    else $error("underrun and overflow together");
`endif

endmodule

// ----- tb/sv/tb_command_byte_fifo_be_reads_core.sv -----
// self-checking testbench for the command byte fifo core: directed table, then biased random
`timescale 1ns / 1ps

module tb_command_byte_fifo_be_reads_core;

  localparam int STORE_BYTES = 4096;

  // short names for the shared operation and width codes
  localparam logic [1:0] OP_PUSH = cbf_pkg::OP_PUSH;
  localparam logic [1:0] OP_READ = cbf_pkg::OP_READ;
  localparam logic [1:0] OP_PEEK = cbf_pkg::OP_PEEK;
  localparam logic [1:0] OP_SKIP = cbf_pkg::OP_SKIP;
  localparam logic [1:0] AW_ONE  = cbf_pkg::AW_ONE;
  localparam logic [1:0] AW_TWO  = cbf_pkg::AW_TWO;

  // width codes the package leaves unnamed
  localparam logic [1:0] AW_FOUR  = 2'd2;
  localparam logic [1:0] AW_SPARE = 2'd3;

  // items per random phase and the trailing wait after the last result
  localparam int PHASE_ITEMS = 400;
  localparam int TAIL_CYCLES = 40;

  // one command item as driven on the in_ ports
  typedef struct packed {
    logic [1:0]       op;
    logic [1:0]       aw;
    logic [11:0]      offset;
    logic [12:0]      skip;
    logic [3:0][63:0] words;
  } cmd_item_t;

  // one result item as seen on the out_ ports
  typedef struct packed {
    logic [31:0] data;
    logic [12:0] fill;
    logic        under;
    logic        over;
  } fifo_result_t;

  // block contents used by the directed table
  typedef enum logic [2:0] {
    PAT_NONE,
    PAT_COUNT,
    PAT_ONES,
    PAT_ZERO,
    PAT_MIXED
  } block_pat_t;

  // directed row: the typed result is used only where typed is set
  typedef struct packed {
    logic [1:0]   op;
    logic [1:0]   aw;
    logic [11:0]  offset;
    logic [12:0]  skip;
    block_pat_t   pat;
    logic         typed;
    fifo_result_t want;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 25;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // empty after reset: every access comes up short, a zero skip is fine
    '{OP_READ, AW_ONE,   12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'h0,        13'd0,  1'b1, 1'b0}},
    '{OP_PEEK, AW_FOUR,  12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'h0,        13'd0,  1'b1, 1'b0}},
    '{OP_SKIP, AW_ONE,   12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'h0,        13'd0,  1'b0, 1'b0}},
    '{OP_SKIP, AW_ONE,   12'd0,    13'd1,    PAT_NONE,  1'b1, '{32'h0,        13'd0,  1'b1, 1'b0}},
    // counting block, then reads of every width including the spare code
    '{OP_PUSH, AW_ONE,   12'd0,    13'd0,    PAT_COUNT, 1'b1, '{32'h0,        13'd32, 1'b0, 1'b0}},
    '{OP_READ, AW_ONE,   12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'h00,       13'd31, 1'b0, 1'b0}},
    '{OP_READ, AW_TWO,   12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'h0102,     13'd29, 1'b0, 1'b0}},
    '{OP_READ, AW_FOUR,  12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'h03040506, 13'd25, 1'b0, 1'b0}},
    '{OP_READ, AW_SPARE, 12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'h0708090a, 13'd21, 1'b0, 1'b0}},
    // peeks at the read point, exactly at the end, one past it, at the far offset
    '{OP_PEEK, AW_FOUR,  12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'h0b0c0d0e, 13'd21, 1'b0, 1'b0}},
    '{OP_PEEK, AW_FOUR,  12'd17,   13'd0,    PAT_NONE,  1'b1, '{32'h1c1d1e1f, 13'd21, 1'b0, 1'b0}},
    '{OP_PEEK, AW_FOUR,  12'd18,   13'd0,    PAT_NONE,  1'b1, '{32'h0,        13'd21, 1'b1, 1'b0}},
    '{OP_PEEK, AW_ONE,   12'd4095, 13'd0,    PAT_NONE,  1'b1, '{32'h0,        13'd21, 1'b1, 1'b0}},
    // oversized skips leave everything alone, an exact one empties the fifo
    '{OP_SKIP, AW_ONE,   12'd0,    13'd4096, PAT_NONE,  1'b1, '{32'h0,        13'd21, 1'b1, 1'b0}},
    '{OP_SKIP, AW_ONE,   12'd0,    13'd8191, PAT_NONE,  1'b1, '{32'h0,        13'd21, 1'b1, 1'b0}},
    '{OP_SKIP, AW_ONE,   12'd0,    13'd21,   PAT_NONE,  1'b1, '{32'h0,        13'd0,  1'b0, 1'b0}},
    '{OP_READ, AW_FOUR,  12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'h0,        13'd0,  1'b1, 1'b0}},
    // all-ones and all-zero blocks
    '{OP_PUSH, AW_ONE,   12'd0,    13'd0,    PAT_ONES,  1'b1, '{32'h0,        13'd32, 1'b0, 1'b0}},
    '{OP_READ, AW_FOUR,  12'd0,    13'd0,    PAT_NONE,  1'b1, '{32'hffffffff, 13'd28, 1'b0, 1'b0}},
    '{OP_PEEK, AW_ONE,   12'd27,   13'd0,    PAT_NONE,  1'b1, '{32'hff,       13'd28, 1'b0, 1'b0}},
    '{OP_PUSH, AW_ONE,   12'd0,    13'd0,    PAT_ZERO,  1'b1, '{32'h0,        13'd60, 1'b0, 1'b0}},
    // mixed content, checked by the predictor
    '{OP_PUSH, AW_ONE,   12'd0,    13'd0,    PAT_MIXED, 1'b0, '0},
    '{OP_PEEK, AW_TWO,   12'd30,   13'd0,    PAT_NONE,  1'b0, '0},
    '{OP_READ, AW_TWO,   12'd0,    13'd0,    PAT_NONE,  1'b0, '0},
    '{OP_SKIP, AW_ONE,   12'd0,    13'd50,   PAT_NONE,  1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         start = 1'b0;
  logic                         busy;
  logic [1:0]                   in_operation = '0;
  logic [1:0]                   in_access_width = '0;
  logic [cbf_pkg::OFFSET_W-1:0] in_peek_offset = '0;
  logic [cbf_pkg::SKIP_W-1:0]   in_skip_count = '0;
  logic [cbf_pkg::WORD_W-1:0]   in_block_word_0 = '0;
  logic [cbf_pkg::WORD_W-1:0]   in_block_word_1 = '0;
  logic [cbf_pkg::WORD_W-1:0]   in_block_word_2 = '0;
  logic [cbf_pkg::WORD_W-1:0]   in_block_word_3 = '0;

  logic                         out_valid;
  logic [cbf_pkg::DATA_W-1:0]   out_read_data;
  logic [cbf_pkg::FILL_W-1:0]   out_fill_level;
  logic                         out_underrun;
  logic                         out_overflow;

  // shadow copy of the fifo: ring of bytes, positions wrap at 12 bits
  logic [7:0]  shadow_bytes [0:STORE_BYTES-1];
  logic [11:0] shadow_rd = '0;
  logic [11:0] shadow_wr = '0;
  logic [12:0] shadow_held = '0;

  // results still owed by the core, oldest first
  fifo_result_t pending_results [$];
  fifo_result_t oldest_result;
  int           mismatches = 0;

  command_byte_fifo_be_reads_core #(
    .STORE_BYTES(STORE_BYTES)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_access_width(in_access_width),
    .in_peek_offset (in_peek_offset),
    .in_skip_count  (in_skip_count),
    .in_block_word_0(in_block_word_0),
    .in_block_word_1(in_block_word_1),
    .in_block_word_2(in_block_word_2),
    .in_block_word_3(in_block_word_3),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_fill_level (out_fill_level),
    .out_underrun   (out_underrun),
    .out_overflow   (out_overflow)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bytes counted per access width code; the spare code reads four
  function automatic int access_bytes(input logic [1:0] code);
    int n;
    case (code)
      AW_ONE:  n = 1;
      AW_TWO:  n = 2;
      default: n = 4;
    endcase
    return n;
  endfunction

  // first byte lands in the most significant position
  function automatic logic [31:0] gather_be(input logic [11:0] from, input int n);
    logic [31:0] v;
    logic [11:0] at;
    v = '0;
    for (int i = 0; i < n; i++) begin
      at = from + 12'(i);
      v = {v[23:0], shadow_bytes[at]};
    end
    return v;
  endfunction

  // advance the shadow fifo by one command and return the result it owes
  function automatic fifo_result_t apply_command(input cmd_item_t c);
    fifo_result_t r;
    int           n;
    logic [11:0]  at;
    r = '0;
    n = access_bytes(c.aw);
    case (c.op)
      OP_PUSH: begin
        // no room for a whole block: the block is dropped
        if (STORE_BYTES - int'(shadow_held) < cbf_pkg::BLOCK_BYTES) begin
          r.over = 1'b1;
        end else begin
          for (int k = 0; k < cbf_pkg::BLOCK_BYTES; k++) begin
            at = shadow_wr + 12'(k);
            shadow_bytes[at] = c.words[k / 8][8 * (k % 8) +: 8];
          end
          shadow_wr = shadow_wr + 12'(cbf_pkg::BLOCK_BYTES);
          shadow_held = shadow_held + 13'(cbf_pkg::BLOCK_BYTES);
        end
      end
      OP_READ: begin
        if (n > int'(shadow_held)) begin
          r.under = 1'b1;
        end else begin
          r.data = gather_be(shadow_rd, n);
          shadow_rd = shadow_rd + 12'(n);
          shadow_held = shadow_held - 13'(n);
        end
      end
      OP_PEEK: begin
        if (int'(c.offset) + n > int'(shadow_held)) r.under = 1'b1;
        else r.data = gather_be(shadow_rd + c.offset, n);
      end
      default: begin
        if (c.skip > shadow_held) begin
          r.under = 1'b1;
        end else begin
          shadow_rd = shadow_rd + c.skip[11:0];
          shadow_held = shadow_held - c.skip;
        end
      end
    endcase
    r.fill = shadow_held;
    return r;
  endfunction

  // random command; filling favors pushes, draining favors reads and skips
  function automatic cmd_item_t random_command(input bit filling);
    cmd_item_t c;
    int        roll;
    int        n;
    c.op = 2'($urandom_range(3));
    c.aw = 2'($urandom_range(3));
    c.offset = 12'($urandom);
    c.skip = 13'($urandom);
    c.words = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
    // a tenth of the items are pure noise
    if ($urandom_range(99) < 10) return c;

    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 60) c.op = OP_PUSH;
      else if (roll < 80) c.op = OP_READ;
      else if (roll < 90) c.op = OP_PEEK;
      else c.op = OP_SKIP;
    end else begin
      if (roll < 15) c.op = OP_PUSH;
      else if (roll < 50) c.op = OP_READ;
      else if (roll < 70) c.op = OP_PEEK;
      else c.op = OP_SKIP;
    end

    // peek mostly inside the held bytes, sometimes just past them
    n = access_bytes(c.aw);
    roll = $urandom_range(99);
    if (int'(shadow_held) >= n && roll < 70)
      c.offset = 12'($urandom_range(int'(shadow_held) - n));
    else if (int'(shadow_held) >= n && roll < 85)
      c.offset = 12'(int'(shadow_held) - n + 1);

    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 90) c.skip = 13'($urandom_range(40));
    end else begin
      if (roll < 60) c.skip = 13'($urandom_range(300));
      else if (roll < 85) c.skip = 13'($urandom_range(int'(shadow_held)));
      else if (roll < 92) c.skip = shadow_held + 13'd1;
    end
    return c;
  endfunction

  // present one item from the falling edge until the core takes it
  task automatic issue(input cmd_item_t c, input logic typed, input fifo_result_t want);
    fifo_result_t predicted;
    @(negedge clk);
    start           <= 1'b1;
    in_operation    <= c.op;
    in_access_width <= c.aw;
    in_peek_offset  <= c.offset;
    in_skip_count   <= c.skip;
    in_block_word_0 <= c.words[0];
    in_block_word_1 <= c.words[1];
    in_block_word_2 <= c.words[2];
    in_block_word_3 <= c.words[3];
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    predicted = apply_command(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // hold off the sender until every owed result has come back
  task automatic wait_results_drained();
    idle_cycle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker: the receiver is always ready, a strobe is an accepted item
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: read_data %h fill %0d underrun %b overflow %b",
                   out_read_data, out_fill_level, out_underrun, out_overflow);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_read_data !== oldest_result.data || out_fill_level !== oldest_result.fill ||
            out_underrun !== oldest_result.under || out_overflow !== oldest_result.over) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch (exp/act): data %h/%h fill %0d/%0d under %b/%b over %b/%b",
                     oldest_result.data, out_read_data, oldest_result.fill, out_fill_level,
                     oldest_result.under, out_underrun, oldest_result.over, out_overflow);
        end
      end
    end
  end

  // stimulus
  initial begin
    cmd_item_t row_cmd;
    stim_row_t row;
    bit        filling;
    int        idle_pct [4];

    // sender idle share per random phase, in percent
    idle_pct = '{0, 59, 25, 0};
    filling = 1'b1;

    // reset held low from time zero, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      row = DIRECTED_ROWS[r];
      row_cmd.op = row.op;
      row_cmd.aw = row.aw;
      row_cmd.offset = row.offset;
      row_cmd.skip = row.skip;
      case (row.pat)
        PAT_COUNT: row_cmd.words = {64'h1f1e1d1c1b1a1918, 64'h1716151413121110,
                                    64'h0f0e0d0c0b0a0908, 64'h0706050403020100};
        PAT_ONES:  row_cmd.words = '1;
        PAT_MIXED: row_cmd.words = {64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5,
                                    64'hfedcba9876543210, 64'h0123456789abcdef};
        default:   row_cmd.words = '0;
      endcase
      issue(row_cmd, row.typed, row.want);
    end
    // sender pauses until the directed results are all back
    wait_results_drained();

    // random phases: fill toward full, drain toward empty, repeat
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        while ($urandom_range(99) < idle_pct[p]) idle_cycle();
        if ($urandom_range(299) == 0) wait_results_drained();
        // linger near full and near empty so overflow and underrun both show up
        if (filling && shadow_held > 13'(STORE_BYTES - cbf_pkg::BLOCK_BYTES) &&
            $urandom_range(3) == 0)
          filling = 1'b0;
        else if (!filling && shadow_held < 13'd64 && $urandom_range(3) == 0)
          filling = 1'b1;
        issue(random_command(filling), 1'b0, '0);
      end
      wait_results_drained();
    end

    // nothing owed any more; watch a push latency for stray strobes
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog, several times the slowest correct run
  initial begin
    #(10_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cbf_pkg.sv
sv/command_byte_fifo_be_reads_core.sv
tb/sv/tb_command_byte_fifo_be_reads_core.sv
